@@ hw/rtl/flc_pkg.sv @@
`timescale 1ns / 1ps

package flc_pkg;

  // default cache depth
  localparam int unsigned CACHE_ENTRIES_DEF = 8;

  // payload widths
  localparam int unsigned FONT_W   = 12;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SLOT_W   = 6;

  // one stored entry: key, handle and use stamp
  localparam int unsigned ENTRY_W = FONT_W + SIZE_W + HANDLE_W + STAMP_W;

  // request type codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } flc_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch request, reset scan
    logic scan;    // compare one entry
    logic commit;  // update cache, load result
  } flc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // current entry ends the scan
  } flc_sts_t;

endpackage

@@ hw/rtl/flc_ram.sv @@
`timescale 1ns / 1ps

module flc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/flc_ctrl.sv @@
`timescale 1ns / 1ps

module flc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  flc_pkg::flc_sts_t sts_i,
  output flc_pkg::flc_cmd_t cmd_o
);

  import flc_pkg::*;

  flc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/flc_dp.sv @@
`timescale 1ns / 1ps

module flc_dp #(
  parameter int unsigned CACHE_ENTRIES = flc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  flc_pkg::flc_cmd_t             cmd_i,
  output flc_pkg::flc_sts_t             sts_o,
  input  logic                          req_type_i,
  input  logic [flc_pkg::FONT_W-1:0]    font_id_i,
  input  logic [flc_pkg::SIZE_W-1:0]    pt_size_i,
  input  logic [flc_pkg::HANDLE_W-1:0]  new_handle_i,
  output logic                          hit_o,
  output logic [flc_pkg::HANDLE_W-1:0]  found_handle_o,
  output logic [flc_pkg::SLOT_W-1:0]    slot_used_o,
  output logic                          evicted_valid_o,
  output logic [flc_pkg::HANDLE_W-1:0]  evicted_handle_o
);

  import flc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  // request registers
  logic                req_type_q;
  logic [FONT_W-1:0]   req_font_q;
  logic [SIZE_W-1:0]   req_size_q;
  logic [HANDLE_W-1:0] req_handle_q;

  // scan state
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    slot_q;
  logic                found_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic                ev_valid_q;
  logic [HANDLE_W-1:0] ev_hdl_q;
  logic [STAMP_W-1:0]  oldest_q;

  // cache state
  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [STAMP_W-1:0]       counter_q;

  // result registers
  logic                hit_q;
  logic [HANDLE_W-1:0] found_handle_q;
  logic [IDX_W-1:0]    slot_used_q;
  logic                evicted_valid_q;
  logic [HANDLE_W-1:0] evicted_handle_q;

  // entry storage
  logic [ENTRY_W-1:0]  rdata;
  logic [ENTRY_W-1:0]  wdata;
  logic [IDX_W-1:0]    raddr;
  logic                we;
  logic [FONT_W-1:0]   rd_font;
  logic [SIZE_W-1:0]   rd_size;
  logic [HANDLE_W-1:0] rd_handle;
  logic [STAMP_W-1:0]  rd_stamp;

  // compare signals
  logic               ent_valid;
  logic               match;
  logic               is_last;
  logic [STAMP_W-1:0] age;
  logic               take_hit;

  assign {rd_font, rd_size, rd_handle, rd_stamp} = rdata;

  // entry compare for the current scan slot
  always_comb begin
    ent_valid = valid_q[idx_q];
    match     = ent_valid && (rd_font == req_font_q) && (rd_size == req_size_q);
    is_last   = (idx_q == LAST_IDX);
    age       = counter_q - rd_stamp;
    take_hit  = (req_type_q == REQ_LOOKUP) && match;
    sts_o.scan_done = take_hit || ((req_type_q == REQ_INSERT) && !ent_valid) || is_last;
  end

  // read address runs one slot ahead of the compare
  always_comb begin
    raddr = '0;
    if (cmd_i.scan && !is_last) begin
      raddr = idx_q + IDX_W'(1);
    end
  end

  // write back on commit: new entry or refreshed stamp
  always_comb begin
    we    = cmd_i.commit && ((req_type_q == REQ_INSERT) || found_q);
    wdata = {req_font_q, req_size_q,
             (req_type_q == REQ_INSERT) ? req_handle_q : hdl_q, counter_q};
  end

  flc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // request capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_type_q   <= req_type_i;
      req_font_q   <= font_id_i;
      req_size_q   <= pt_size_i;
      req_handle_q <= new_handle_i;
      idx_q        <= '0;
      slot_q       <= '0;
      found_q      <= 1'b0;
      hdl_q        <= '0;
      ev_valid_q   <= 1'b0;
      ev_hdl_q     <= '0;
      oldest_q     <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + IDX_W'(1);
      if (req_type_q == REQ_LOOKUP) begin
        if (match) begin
          found_q <= 1'b1;
          slot_q  <= idx_q;
          hdl_q   <= rd_handle;
        end
      end else if (!ent_valid) begin
        // empty slot wins outright
        slot_q     <= idx_q;
        ev_valid_q <= 1'b0;
      end else if ((idx_q == '0) || (oldest_q < age)) begin
        oldest_q   <= age;
        slot_q     <= idx_q;
        ev_valid_q <= 1'b1;
        ev_hdl_q   <= rd_handle;
      end
    end
  end

  // valid bits and use counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      counter_q <= '0;
    end else if (we) begin
      valid_q[slot_q] <= 1'b1;
      counter_q       <= counter_q + STAMP_W'(1);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q            <= (req_type_q == REQ_LOOKUP) && found_q;
      found_handle_q   <= ((req_type_q == REQ_LOOKUP) && found_q) ? hdl_q : '0;
      slot_used_q      <= slot_q;
      evicted_valid_q  <= (req_type_q == REQ_INSERT) && ev_valid_q;
      evicted_handle_q <= ((req_type_q == REQ_INSERT) && ev_valid_q) ? ev_hdl_q : '0;
    end
  end

  assign hit_o            = hit_q;
  assign found_handle_o   = found_handle_q;
  assign slot_used_o      = SLOT_W'(slot_used_q);
  assign evicted_valid_o  = evicted_valid_q;
  assign evicted_handle_o = evicted_handle_q;

endmodule

@@ hw/rtl/font_handle_lru_cache_top.sv @@
`timescale 1ns / 1ps
// result: valid once the scan ends and the commit is taken; the scan ends early when a lookup
//   hits or an insert finds an empty slot, else at the last entry
// flow: one request at a time; the request is taken, then one entry is read per cycle,
//   then the result is committed once the result register is free
// reset: asynchronous active low; empties the cache (valid bits) and clears the use counter
module font_handle_lru_cache_top #(
  parameter int unsigned CACHE_ENTRIES = flc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [flc_pkg::FONT_W-1:0]    font_id_i,
  input  logic [flc_pkg::SIZE_W-1:0]    pt_size_i,
  input  logic [flc_pkg::HANDLE_W-1:0]  new_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [flc_pkg::HANDLE_W-1:0]  found_handle_o,
  output logic [flc_pkg::SLOT_W-1:0]    slot_used_o,
  output logic                          evicted_valid_o,
  output logic [flc_pkg::HANDLE_W-1:0]  evicted_handle_o
);

  import flc_pkg::*;

  flc_cmd_t cmd;
  flc_sts_t sts;

  // sequencer
  flc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // entry storage, compare and replacement
  flc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .font_id_i        (font_id_i),
    .pt_size_i        (pt_size_i),
    .new_handle_i     (new_handle_i),
    .hit_o            (hit_o),
    .found_handle_o   (found_handle_o),
    .slot_used_o      (slot_used_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_handle_o (evicted_handle_o)
  );

endmodule

@@ hw/rtl/flc_checker.sv @@
`timescale 1ns / 1ps

module flc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          req_type_i,
  input logic [flc_pkg::FONT_W-1:0]    font_id_i,
  input logic [flc_pkg::SIZE_W-1:0]    pt_size_i,
  input logic [flc_pkg::HANDLE_W-1:0]  new_handle_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          hit_o,
  input logic [flc_pkg::HANDLE_W-1:0]  found_handle_o,
  input logic [flc_pkg::SLOT_W-1:0]    slot_used_o,
  input logic                          evicted_valid_o,
  input logic [flc_pkg::HANDLE_W-1:0]  evicted_handle_o
);

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken during scan");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("hit and eviction in one result");

  // miss or insert carries a zero found handle
  a_miss_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_handle_o == '0)
    else $error("found handle set without hit");

  // no eviction carries a zero evicted handle
  a_evict_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_handle_o == '0)
    else $error("evicted handle set without eviction");

endmodule

bind font_handle_lru_cache_top flc_checker u_flc_checker (.*);

@@ tb/sv/font_handle_lru_cache_top_tb.sv @@
`timescale 1ns / 1ps

module font_handle_lru_cache_top_tb;
  import flc_pkg::*;

  localparam int unsigned DEPTH       = CACHE_ENTRIES_DEF;
  localparam int unsigned KEY_POOL    = 12;
  localparam int unsigned PHASE_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // one request and one result as seen on the ports
  typedef struct packed {
    logic                req_type;
    logic [FONT_W-1:0]   font_id;
    logic [SIZE_W-1:0]   pt_size;
    logic [HANDLE_W-1:0] new_handle;
  } font_req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic [SLOT_W-1:0]   slot_used;
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } font_res_t;

  // cache mirror: predicts each result and checks the block's answers in order
  class font_cache_scoreboard;
    bit                  slot_valid  [DEPTH];
    logic [FONT_W-1:0]   slot_font   [DEPTH];
    logic [SIZE_W-1:0]   slot_size   [DEPTH];
    logic [HANDLE_W-1:0] slot_handle [DEPTH];
    logic [STAMP_W-1:0]  slot_stamp  [DEPTH];
    logic [STAMP_W-1:0]  use_count;
    font_res_t           pending_results [$];
    int unsigned         mismatches;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_valid[i]  = 1'b0;
        slot_font[i]   = '0;
        slot_size[i]   = '0;
        slot_handle[i] = '0;
        slot_stamp[i]  = '0;
      end
      use_count  = '0;
      mismatches = 0;
    endfunction

    // apply an accepted request to the mirror and queue its result
    function void note_request(font_req_t r);
      font_res_t          res;
      int unsigned        victim;
      logic [STAMP_W-1:0] oldest;
      logic [STAMP_W-1:0] age;
      res = '0;
      if (r.req_type == REQ_LOOKUP) begin
        // first matching valid slot wins
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i] && slot_font[i] == r.font_id && slot_size[i] == r.pt_size) begin
            res.hit          = 1'b1;
            res.found_handle = slot_handle[i];
            res.slot_used    = SLOT_W'(i);
            slot_stamp[i]    = use_count;
            use_count        = use_count + 1;
            break;
          end
        end
      end else begin
        // first empty slot, else greatest wrapped age, lowest slot on ties
        victim = 0;
        oldest = '0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!slot_valid[i]) begin
            victim = i;
            break;
          end
          age = use_count - slot_stamp[i];
          if (oldest < age) begin
            oldest = age;
            victim = i;
          end
        end
        if (slot_valid[victim]) begin
          res.evicted_valid  = 1'b1;
          res.evicted_handle = slot_handle[victim];
        end
        slot_valid[victim]  = 1'b1;
        slot_font[victim]   = r.font_id;
        slot_size[victim]   = r.pt_size;
        slot_handle[victim] = r.new_handle;
        slot_stamp[victim]  = use_count;
        use_count           = use_count + 1;
        res.slot_used       = SLOT_W'(victim);
      end
      pending_results.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare a delivered result with the oldest prediction
    function void check_result(font_res_t got);
      font_res_t want;
      if (pending_results.size() == 0) begin
        $error("result delivered with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      check_field("hit", 32'(want.hit), 32'(got.hit));
      check_field("found_handle", 32'(want.found_handle), 32'(got.found_handle));
      check_field("slot_used", 32'(want.slot_used), 32'(got.slot_used));
      check_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
      check_field("evicted_handle", 32'(want.evicted_handle), 32'(got.evicted_handle));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                req_type_i;
  logic [FONT_W-1:0]   font_id_i;
  logic [SIZE_W-1:0]   pt_size_i;
  logic [HANDLE_W-1:0] new_handle_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                hit_o;
  logic [HANDLE_W-1:0] found_handle_o;
  logic [SLOT_W-1:0]   slot_used_o;
  logic                evicted_valid_o;
  logic [HANDLE_W-1:0] evicted_handle_o;

  font_cache_scoreboard sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          cycle_count = 0;
  logic [FONT_W-1:0]    pool_font [KEY_POOL];
  logic [SIZE_W-1:0]    pool_size [KEY_POOL];

  font_handle_lru_cache_top #(
    .CACHE_ENTRIES(DEPTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .font_id_i        (font_id_i),
    .pt_size_i        (pt_size_i),
    .new_handle_i     (new_handle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .found_handle_o   (found_handle_o),
    .slot_used_o      (slot_used_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_handle_o (evicted_handle_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watch both handshakes on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_request({req_type_i, font_id_i, pt_size_i, new_handle_i});
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({hit_o, found_handle_o, slot_used_o, evicted_valid_o, evicted_handle_o});
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("font_handle_lru_cache_top regression: fail");
    $finish;
  end

  // present one request after optional idle cycles; returns on the next falling edge
  task automatic send_request(font_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= r.req_type;
    font_id_i    <= r.font_id;
    pt_size_i    <= r.pt_size;
    new_handle_i <= r.new_handle;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_key(logic kind, logic [FONT_W-1:0] font, logic [SIZE_W-1:0] size,
                          logic [HANDLE_W-1:0] handle);
    font_req_t r;
    r.req_type   = kind;
    r.font_id    = font;
    r.pt_size    = size;
    r.new_handle = handle;
    send_request(r);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
  endtask

  // small key set so lookups hit and inserts evict often
  task automatic fill_key_pool();
    pool_font[0] = '0;
    pool_size[0] = '0;
    pool_font[1] = '1;
    pool_size[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) begin
      pool_font[i] = FONT_W'($urandom);
      pool_size[i] = SIZE_W'($urandom);
    end
  endtask

  function automatic font_req_t random_request();
    font_req_t   r;
    int unsigned k;
    r.req_type = ($urandom_range(99) < 35) ? REQ_INSERT : REQ_LOOKUP;
    if ($urandom_range(99) < 75) begin
      k         = $urandom_range(KEY_POOL - 1);
      r.font_id = pool_font[k];
      r.pt_size = pool_size[k];
    end else begin
      r.font_id = FONT_W'($urandom);
      r.pt_size = SIZE_W'($urandom);
    end
    r.new_handle = HANDLE_W'($urandom);
    return r;
  endfunction

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_LOOKUP;
    font_id_i     = '0;
    pt_size_i     = '0;
    new_handle_i  = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 49;
    sb = new();

    // reset
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty miss, extremes, duplicate keys, fill and evict
    send_key(REQ_LOOKUP, '0, '0, '0);
    send_key(REQ_INSERT, '0, '0, '0);
    send_key(REQ_INSERT, '1, '1, '1);
    send_key(REQ_INSERT, '1, '1, 8'h5a);
    send_key(REQ_LOOKUP, '1, '1, '1);
    send_key(REQ_LOOKUP, '0, '0, '1);
    send_key(REQ_LOOKUP, '1, '0, '0);
    send_key(REQ_LOOKUP, '0, '1, '0);
    for (int i = 0; i < DEPTH - 3; i++) begin
      send_key(REQ_INSERT, FONT_W'(12'h101 + i), SIZE_W'(16'h0a00 + i), HANDLE_W'(8'h10 + i));
    end
    send_key(REQ_INSERT, 12'h800, 16'h8000, 8'h80);
    send_key(REQ_INSERT, 12'h7ff, 16'h7fff, 8'h7f);
    send_key(REQ_LOOKUP, '1, '1, '0);
    send_key(REQ_LOOKUP, 12'h800, 16'h8000, '1);
    send_key(REQ_INSERT, 12'h555, 16'haaaa, 8'haa);
    send_key(REQ_LOOKUP, 12'h555, 16'haaaa, 8'h55);
    drain();

    // random phases: receiver stalls more, then sender idles more, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      fill_key_pool();
      repeat (PHASE_ITEMS) send_request(random_request());
      drain();
    end

    // let any stray result show up
    repeat (4 * (DEPTH + 2)) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("font_handle_lru_cache_top regression: pass");
    end else begin
      $display("font_handle_lru_cache_top regression: fail");
    end
    $finish;
  end

endmodule
